[rtl/swm_pkg.sv]
// Shared types and constants of the sliding window median unit.
// No dependencies; every other file of the unit imports this package.

package swm_pkg;

  // Default built depth of the window.
  localparam int WINDOW_MAX_DEF = 64;

  // Field widths.
  localparam int CFG_W    = 7;
  localparam int SAMPLE_W = 32;
  localparam int RESULT_W = 33;

  // Smallest sample value; used as the left boundary of the cell row.
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Window size after reset.
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = CFG_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] median_x2;
    logic                       last_result;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                       start;
    logic                       clear;
    logic signed [SAMPLE_W-1:0] x;
  } cell_ctrl_t;

endpackage

[rtl/swm_cell.sv]
// One cell of the sorted sample row: holds one sample with its age and
// one stage of the rank counting wave. Depends on swm_pkg.

module swm_cell import swm_pkg::*; #(
  parameter int              AW      = 6,
  parameter int              CW      = 7,
  parameter logic [AW-1:0]   AGE_OLD = '1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [CW-1:0]       k_i,
  input  logic [CW-1:0]       rank_lo_i,
  input  logic [CW-1:0]       rank_hi_i,
  // Left neighbor.
  input  logic                l_valid_i,
  input  logic [SAMPLE_W-1:0] l_value_i,
  input  logic [AW-1:0]       l_age_i,
  input  logic                l_mr_i,
  // Right neighbor.
  input  logic                r_valid_i,
  input  logic [SAMPLE_W-1:0] r_value_i,
  input  logic [AW-1:0]       r_age_i,
  input  logic                r_ml_i,
  // Own contents.
  output logic                valid_o,
  output logic [SAMPLE_W-1:0] value_o,
  output logic [AW-1:0]       age_o,
  output logic                hole_o,
  output logic                mr_o,
  output logic                ml_o,
  // Counting wave.
  input  logic                w_vld_i,
  input  logic [CW-1:0]       w_cnt_i,
  input  logic [SAMPLE_W-1:0] w_lo_i,
  input  logic [SAMPLE_W-1:0] w_hi_i,
  output logic                w_vld_o,
  output logic [CW-1:0]       w_cnt_o,
  output logic [SAMPLE_W-1:0] w_lo_o,
  output logic [SAMPLE_W-1:0] w_hi_o
);

  logic                valid_q, valid_d;
  logic                hole_q, hole_d;
  logic [SAMPLE_W-1:0] value_q, value_d;
  logic [AW-1:0]       age_q, age_d;
  logic                w_vld_q;
  logic [CW-1:0]       w_cnt_q, w_cnt_d;
  logic [SAMPLE_W-1:0] w_lo_q, w_lo_d, w_hi_q, w_hi_d;
  logic                in_win;

  // The hole walks toward the spot where the new sample keeps the row sorted.
  assign mr_o = hole_q && r_valid_i && ($signed(r_value_i) < ctrl_i.x);
  assign ml_o = hole_q && ($signed(l_value_i) > ctrl_i.x);

  always_comb begin
    valid_d = valid_q;
    hole_d  = hole_q;
    value_d = value_q;
    age_d   = age_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
      hole_d  = 1'b0;
    end else if (ctrl_i.start) begin
      // The oldest sample of a full row, or the first free cell, opens the hole.
      if (valid_q) begin
        if (age_q == AGE_OLD) begin
          hole_d  = 1'b1;
          valid_d = 1'b0;
        end else begin
          age_d = age_q + 1'b1;
        end
      end else if (l_valid_i) begin
        hole_d = 1'b1;
      end
    end else if (hole_q) begin
      hole_d = 1'b0;
      if (mr_o) begin
        valid_d = r_valid_i;
        value_d = r_value_i;
        age_d   = r_age_i;
      end else if (ml_o) begin
        valid_d = l_valid_i;
        value_d = l_value_i;
        age_d   = l_age_i;
      end else begin
        valid_d = 1'b1;
        value_d = ctrl_i.x;
        age_d   = '0;
      end
    end else if (l_mr_i || r_ml_i) begin
      hole_d  = 1'b1;
      valid_d = 1'b0;
    end
  end

  assign in_win  = valid_q && (CW'(age_q) < k_i);
  assign w_cnt_d = w_cnt_i + CW'(in_win);
  assign w_lo_d  = (in_win && (w_cnt_i == rank_lo_i)) ? value_q : w_lo_i;
  assign w_hi_d  = (in_win && (w_cnt_i == rank_hi_i)) ? value_q : w_hi_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hole_q  <= 1'b0;
      w_vld_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hole_q  <= hole_d;
      w_vld_q <= w_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    age_q   <= age_d;
    w_cnt_q <= w_cnt_d;
    w_lo_q  <= w_lo_d;
    w_hi_q  <= w_hi_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign age_o   = age_q;
  assign hole_o  = hole_q;
  assign w_vld_o = w_vld_q;
  assign w_cnt_o = w_cnt_q;
  assign w_lo_o  = w_lo_q;
  assign w_hi_o  = w_hi_q;

endmodule

[rtl/sliding_window_median_unit.sv]
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_data_i  (in_item_t)
// out       output     out_valid_o / out_stall_i out_data_o (out_item_t)
// cfg       input      cfg_we_i                  cfg_wdata_i (window size)
//
// One item at a time. An item's sample is placed in the row once the free slot
// has walked cell by cell to its sorted spot (up to WINDOW_MAX - 1 cells); then,
// when the window is full, the counting wave runs along the row and the result
// is loaded into the output register.
// Reset empties the row and sets the window size to 1; no clearing pass.
// A stalled result waits in the output register; the next item may enter.

module sliding_window_median_unit import swm_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam logic [AW-1:0] AGE_OLD = AW'(WINDOW_MAX - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_OUTPUT
  } state_e;

  state_e                     state_q;
  logic [CFG_W-1:0]           win_size_q;
  logic [CW-1:0]              fill_q;
  logic                       last_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [RESULT_W-1:0] res_q;
  logic                       out_valid_q;
  out_item_t                  out_data_q;

  logic [CW-1:0] k_eff, rank_lo, rank_hi;
  logic          in_accept, need_result, any_hole, out_free, scan_done, wave_start;
  cell_ctrl_t    ctrl;

  logic [WINDOW_MAX-1:0] valid_w, hole_w, mr_w, ml_w, wv_w;
  logic [SAMPLE_W-1:0]   value_w [WINDOW_MAX];
  logic [AW-1:0]         age_w   [WINDOW_MAX];
  logic [CW-1:0]         wcnt_w  [WINDOW_MAX];
  logic [SAMPLE_W-1:0]   wlo_w   [WINDOW_MAX];
  logic [SAMPLE_W-1:0]   whi_w   [WINDOW_MAX];

  // A size of zero counts as one; a size beyond the row counts as the row.
  always_comb begin
    if (win_size_q == '0) begin
      k_eff = CW'(1);
    end else if (32'(win_size_q) > 32'(WINDOW_MAX)) begin
      k_eff = CW'(WINDOW_MAX);
    end else begin
      k_eff = CW'(win_size_q);
    end
  end

  assign rank_lo = (k_eff - CW'(1)) >> 1;
  assign rank_hi = k_eff >> 1;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign need_result = (fill_q >= k_eff);
  assign any_hole    = |hole_w;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign scan_done   = wv_w[WINDOW_MAX-1];
  assign wave_start  = (state_q == ST_INSERT) && !any_hole && need_result;

  always_comb begin
    ctrl.start = in_accept;
    ctrl.x     = in_accept ? in_data_i.sample : x_q;
    ctrl.clear = last_q &&
                 (((state_q == ST_INSERT) && !any_hole && !need_result) ||
                  ((state_q == ST_OUTPUT) && out_free));
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                l_valid, l_mr, r_valid, r_ml, w_vld_in;
    logic [SAMPLE_W-1:0] l_value, r_value, w_lo_in, w_hi_in;
    logic [AW-1:0]       l_age, r_age;
    logic [CW-1:0]       w_cnt_in;

    if (i == 0) begin : g_left_edge
      assign l_valid  = 1'b1;
      assign l_value  = SAMPLE_MIN;
      assign l_age    = '0;
      assign l_mr     = 1'b0;
      assign w_vld_in = wave_start;
      assign w_cnt_in = '0;
      assign w_lo_in  = '0;
      assign w_hi_in  = '0;
    end else begin : g_left
      assign l_valid  = valid_w[i-1];
      assign l_value  = value_w[i-1];
      assign l_age    = age_w[i-1];
      assign l_mr     = mr_w[i-1];
      assign w_vld_in = wv_w[i-1];
      assign w_cnt_in = wcnt_w[i-1];
      assign w_lo_in  = wlo_w[i-1];
      assign w_hi_in  = whi_w[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_right_edge
      assign r_valid = 1'b0;
      assign r_value = '0;
      assign r_age   = '0;
      assign r_ml    = 1'b0;
    end else begin : g_right
      assign r_valid = valid_w[i+1];
      assign r_value = value_w[i+1];
      assign r_age   = age_w[i+1];
      assign r_ml    = ml_w[i+1];
    end

    swm_cell #(
      .AW      (AW),
      .CW      (CW),
      .AGE_OLD (AGE_OLD)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .k_i       (k_eff),
      .rank_lo_i (rank_lo),
      .rank_hi_i (rank_hi),
      .l_valid_i (l_valid),
      .l_value_i (l_value),
      .l_age_i   (l_age),
      .l_mr_i    (l_mr),
      .r_valid_i (r_valid),
      .r_value_i (r_value),
      .r_age_i   (r_age),
      .r_ml_i    (r_ml),
      .valid_o   (valid_w[i]),
      .value_o   (value_w[i]),
      .age_o     (age_w[i]),
      .hole_o    (hole_w[i]),
      .mr_o      (mr_w[i]),
      .ml_o      (ml_w[i]),
      .w_vld_i   (w_vld_in),
      .w_cnt_i   (w_cnt_in),
      .w_lo_i    (w_lo_in),
      .w_hi_i    (w_hi_in),
      .w_vld_o   (wv_w[i]),
      .w_cnt_o   (wcnt_w[i]),
      .w_lo_o    (wlo_w[i]),
      .w_hi_o    (whi_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_size_q  <= WINDOW_SIZE_RST;
      fill_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_size_q <= cfg_wdata_i;
      end
      if ((state_q == ST_OUTPUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            last_q  <= in_data_i.last_sample;
            state_q <= ST_INSERT;
            if (fill_q != CW'(WINDOW_MAX)) begin
              fill_q <= fill_q + CW'(1);
            end
          end
        end
        ST_INSERT: begin
          if (!any_hole) begin
            if (need_result) begin
              state_q <= ST_SCAN;
            end else begin
              if (last_q) begin
                fill_q <= '0;
              end
              state_q <= ST_IDLE;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= ST_OUTPUT;
          end
        end
        ST_OUTPUT: begin
          if (out_free) begin
            if (last_q) begin
              fill_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q <= in_data_i.sample;
    end
    if ((state_q == ST_SCAN) && scan_done) begin
      res_q <= $signed({wlo_w[WINDOW_MAX-1][SAMPLE_W-1], wlo_w[WINDOW_MAX-1]}) +
               $signed({whi_w[WINDOW_MAX-1][SAMPLE_W-1], whi_w[WINDOW_MAX-1]});
    end
    if ((state_q == ST_OUTPUT) && out_free) begin
      out_data_q.median_x2   <= res_q;
      out_data_q.last_result <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/swm_checker.sv]
// Port level checks of the sliding window median unit, bound to the top level.
// Depends on swm_pkg and sliding_window_median_unit.

module swm_checker import swm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input logic [CFG_W-1:0] cfg_wdata_i,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input in_item_t         in_data_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input out_item_t        out_data_o
);

  // While reset is held the unit shows no result and is ready for an item.
  a_reset_quiet : assert property (@(posedge clk_i)
    (!rst_ni && $past(!rst_ni)) |-> (!out_valid_o && !in_stall_o))
    else $error("unit not quiet in reset");

  // An accepted item keeps the input side stalled until its work is done.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted item");

  // A new result only appears at the end of an item's work.
  a_result_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(in_stall_o) && !in_stall_o))
    else $error("result appeared outside the end of an item");

  // A stalled result holds.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind sliding_window_median_unit swm_checker u_swm_checker (.*);
